>>> design/cyclic_voltammetry_sequencer_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the cyclic voltammetry sequencer
// Implication and next-cycle implication checks, clocked on clk and
// disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef CYCLIC_VOLTAMMETRY_SEQUENCER_TOP_ASSERT_SVH
`define CYCLIC_VOLTAMMETRY_SEQUENCER_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CVS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CVS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/cvs_pkg.sv
// ----------------------------------------------------------------------------
// Cyclic voltammetry sequencer package
// Codes, field widths and register reset values shared by the design.
// ----------------------------------------------------------------------------
package cvs_pkg;

    localparam int CURRENT_BITS_DEF = 24;
    localparam int POT_BITS         = 15;
    localparam int CELL_BITS        = 16;
    localparam int STEP_TIME_BITS   = 16;
    localparam int WAIT_BITS        = 20;
    localparam int CYCLE_BITS       = 8;
    localparam int CFG_INDEX_BITS   = 3;
    localparam int CFG_DATA_BITS    = 20;
    // Candidate potentials and their distance to a vertex need this headroom
    localparam int WIDE_BITS        = 18;

    // +-1000 mV in 0.1 mV units
    localparam logic signed [POT_BITS-1:0] POT_LIMIT     = 15'sd10000;
    localparam logic signed [POT_BITS-1:0] POT_LIMIT_NEG = -15'sd10000;

    localparam logic signed [POT_BITS-1:0]  BEGIN_RST      = 15'sd0;
    localparam logic signed [POT_BITS-1:0]  VERTEX_ONE_RST = 15'sd5000;
    localparam logic signed [POT_BITS-1:0]  VERTEX_TWO_RST = -15'sd5000;
    localparam logic [POT_BITS-1:0]         STEP_SIZE_RST  = 15'd10;
    localparam logic [STEP_TIME_BITS-1:0]   STEP_TIME_RST  = 16'd10;
    localparam logic [WAIT_BITS-1:0]        EQUIL_RST      = 20'd0;
    localparam logic [CYCLE_BITS-1:0]       CYCLE_RST      = 8'd1;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_EQUIL = 3'd1,
        PH_SWEEP = 3'd2,
        PH_DONE  = 3'd3,
        PH_ABORT = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        MODE_START = 2'd0,
        MODE_TICK  = 2'd1,
        MODE_ABORT = 2'd2,
        MODE_NOP   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ERR_NONE   = 2'd0,
        ERR_RANGE  = 2'd1,
        ERR_STEP   = 2'd2,
        ERR_CYCLES = 2'd3
    } err_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_BEGIN      = 3'd0,
        REG_VERTEX_ONE = 3'd1,
        REG_VERTEX_TWO = 3'd2,
        REG_STEP_SIZE  = 3'd3,
        REG_STEP_TIME  = 3'd4,
        REG_EQUIL      = 3'd5,
        REG_CYCLES     = 3'd6,
        REG_NONE       = 3'd7
    } reg_index_t;

    typedef enum logic [1:0] {
        SEG_RISE   = 2'd0,
        SEG_CROSS  = 2'd1,
        SEG_RETURN = 2'd2,
        SEG_UNUSED = 2'd3
    } seg_t;

endpackage

>>> design/cyclic_voltammetry_sequencer_top.sv
// ----------------------------------------------------------------------------
// Cyclic voltammetry sequencer
// Staircase waveform sequencer: start check, equilibration, swept cycles
// and per-step sampling, one result beat for every input beat.
// ----------------------------------------------------------------------------
// Every input beat (start, millisecond tick, abort or no-op) yields exactly one
// result beat. A new beat is taken every cycle; a beat is held in the input
// register and then in the result register, so the throughput is one beat per
// cycle, held back only by out_stall. The per-step work is one compare-and-add
// per segment, evaluated for up to four segments in parallel so that empty
// segments and exhausted cycles are skipped within the same beat. Configuration
// is taken on the cfg channel whenever no beat sits in the input register; write
// it only while the sequencer is not running. Points are recorded on tick
// beats only.
module cyclic_voltammetry_sequencer_top #(
    parameter int CURRENT_BITS = cvs_pkg::CURRENT_BITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,

    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic [1:0]                             mode,
    input  logic signed [CURRENT_BITS-1:0]         current_sample,
    input  logic signed [cvs_pkg::CELL_BITS-1:0]   cell_sample,

    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic                                   point_valid,
    output logic signed [cvs_pkg::POT_BITS-1:0]    point_potential,
    output logic signed [CURRENT_BITS-1:0]         point_current,
    output logic signed [cvs_pkg::CELL_BITS-1:0]   point_cell_voltage,
    output logic signed [cvs_pkg::POT_BITS-1:0]    setpoint,
    output logic [2:0]                             phase,
    output logic [1:0]                             error_code,

    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [cvs_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [cvs_pkg::CFG_DATA_BITS-1:0]      cfg_data
);

    localparam int PB = cvs_pkg::POT_BITS;
    localparam int WB = cvs_pkg::WIDE_BITS;

    // Configuration registers
    logic signed [PB-1:0]                       begin_reg;
    logic signed [PB-1:0]                       vertex_one_reg;
    logic signed [PB-1:0]                       vertex_two_reg;
    logic [PB-1:0]                              step_size_reg;
    logic [cvs_pkg::STEP_TIME_BITS-1:0]         step_time_reg;
    logic [cvs_pkg::WAIT_BITS-1:0]              equil_reg;
    logic [cvs_pkg::CYCLE_BITS-1:0]             cycles_cfg_reg;

    // Input register
    logic                                       s1_valid_reg;
    cvs_pkg::mode_t                             s1_mode_reg;
    logic signed [CURRENT_BITS-1:0]             s1_current_reg;
    logic signed [cvs_pkg::CELL_BITS-1:0]       s1_cell_reg;

    // Sequencer state
    cvs_pkg::phase_t                            phase_reg;
    cvs_pkg::phase_t                            phase_next;
    logic signed [PB-1:0]                       drive_reg;
    logic signed [PB-1:0]                       drive_next;
    logic [1:0]                                 seg_reg;
    logic [1:0]                                 seg_next;
    logic [cvs_pkg::CYCLE_BITS-1:0]             cycles_left_reg;
    logic [cvs_pkg::CYCLE_BITS-1:0]             cycles_left_next;
    logic [cvs_pkg::WAIT_BITS-1:0]              wait_reg;
    logic [cvs_pkg::WAIT_BITS-1:0]              wait_next;

    // Result register
    logic                                       out_valid_reg;
    logic                                       out_point_valid_reg;
    logic signed [PB-1:0]                       out_point_pot_reg;
    logic signed [CURRENT_BITS-1:0]             out_point_cur_reg;
    logic signed [cvs_pkg::CELL_BITS-1:0]       out_point_cell_reg;
    logic signed [PB-1:0]                       out_setpoint_reg;
    cvs_pkg::phase_t                            out_phase_reg;
    cvs_pkg::err_t                              out_err_reg;

    logic                                       pipe_move;
    logic                                       do_step;
    logic                                       running;
    logic [cvs_pkg::WAIT_BITS-1:0]              wait_dec;
    logic                                       sample_hit;
    cvs_pkg::err_t                              chk_err;
    logic [cvs_pkg::WAIT_BITS-1:0]              step_load;
    logic [cvs_pkg::WAIT_BITS-1:0]              equil_load;

    // Result payload computed from the input register
    logic                                       res_point_valid;
    logic signed [PB-1:0]                       res_point_pot;
    logic signed [CURRENT_BITS-1:0]             res_point_cur;
    logic signed [cvs_pkg::CELL_BITS-1:0]       res_point_cell;
    cvs_pkg::err_t                              res_err;

    // Segment lookahead
    logic [1:0]                                 seg_start;
    logic [1:0]                                 adv_seg;
    logic [cvs_pkg::CYCLE_BITS-1:0]             adv_cyc;
    logic                                       adv_found;
    logic                                       adv_end;
    logic signed [PB-1:0]                       adv_drive;
    logic                                       adv_hit;
    logic signed [WB-1:0]                       adv_cand;
    logic signed [WB-1:0]                       step_ext;
    logic signed [PB-1:0]                       seg_a [3];
    logic signed [PB-1:0]                       seg_b [3];
    logic signed [WB-1:0]                       first_cand [3];
    logic [2:0]                                 first_hit;
    logic signed [WB-1:0]                       cont_cand;
    logic                                       cont_hit;

    // Next level one step from 'from' toward b
    function automatic logic signed [WB-1:0] step_level(
        input logic signed [PB-1:0] a,
        input logic signed [PB-1:0] b,
        input logic signed [WB-1:0] from,
        input logic signed [WB-1:0] stp
    );
        return (b >= a) ? from + stp : from - stp;
    endfunction

    // Candidate has not passed the segment end
    function automatic logic step_fits(
        input logic signed [PB-1:0] a,
        input logic signed [PB-1:0] b,
        input logic signed [WB-1:0] cand
    );
        logic signed [WB-1:0] diff;
        diff = WB'(b) - cand;
        return (b >= a) ? !diff[WB-1] : (diff[WB-1] || diff == '0);
    endfunction

    // ------------------------------------------------------------------
    // Handshakes
    // ------------------------------------------------------------------
    assign pipe_move = !out_valid_reg || !out_stall;
    assign in_stall  = s1_valid_reg && !pipe_move;
    assign do_step   = s1_valid_reg && pipe_move;
    assign cfg_ready = !s1_valid_reg;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            begin_reg      <= cvs_pkg::BEGIN_RST;
            vertex_one_reg <= cvs_pkg::VERTEX_ONE_RST;
            vertex_two_reg <= cvs_pkg::VERTEX_TWO_RST;
            step_size_reg  <= cvs_pkg::STEP_SIZE_RST;
            step_time_reg  <= cvs_pkg::STEP_TIME_RST;
            equil_reg      <= cvs_pkg::EQUIL_RST;
            cycles_cfg_reg <= cvs_pkg::CYCLE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cvs_pkg::reg_index_t'(cfg_index))
                cvs_pkg::REG_BEGIN:      begin_reg      <= cfg_data[PB-1:0];
                cvs_pkg::REG_VERTEX_ONE: vertex_one_reg <= cfg_data[PB-1:0];
                cvs_pkg::REG_VERTEX_TWO: vertex_two_reg <= cfg_data[PB-1:0];
                cvs_pkg::REG_STEP_SIZE:  step_size_reg  <= cfg_data[PB-1:0];
                cvs_pkg::REG_STEP_TIME:
                    step_time_reg <= cfg_data[cvs_pkg::STEP_TIME_BITS-1:0];
                cvs_pkg::REG_EQUIL:
                    equil_reg <= cfg_data[cvs_pkg::WAIT_BITS-1:0];
                cvs_pkg::REG_CYCLES:
                    cycles_cfg_reg <= cfg_data[cvs_pkg::CYCLE_BITS-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_mode_reg    <= cvs_pkg::mode_t'(mode);
            s1_current_reg <= current_sample;
            s1_cell_reg    <= cell_sample;
        end
    end

    // ------------------------------------------------------------------
    // Shared decode
    // ------------------------------------------------------------------
    assign running   = (phase_reg == cvs_pkg::PH_EQUIL) || (phase_reg == cvs_pkg::PH_SWEEP);
    assign wait_dec  = (wait_reg == '0) ? wait_reg : wait_reg - 1'b1;
    assign sample_hit = (s1_mode_reg == cvs_pkg::MODE_TICK) && running && (wait_dec == '0);

    // A zero wait behaves as one tick
    assign step_load  = (step_time_reg == '0) ? cvs_pkg::WAIT_BITS'(1)
                                              : cvs_pkg::WAIT_BITS'(step_time_reg);
    assign equil_load = (equil_reg == '0) ? cvs_pkg::WAIT_BITS'(1) : equil_reg;

    always_comb
    begin
        chk_err = cvs_pkg::ERR_NONE;
        if (begin_reg < cvs_pkg::POT_LIMIT_NEG || begin_reg > cvs_pkg::POT_LIMIT ||
            vertex_one_reg < cvs_pkg::POT_LIMIT_NEG || vertex_one_reg > cvs_pkg::POT_LIMIT ||
            vertex_two_reg < cvs_pkg::POT_LIMIT_NEG || vertex_two_reg > cvs_pkg::POT_LIMIT)
        begin
            chk_err = cvs_pkg::ERR_RANGE;
        end
        else if (step_size_reg == '0)
        begin
            chk_err = cvs_pkg::ERR_STEP;
        end
        else if (cycles_cfg_reg == '0)
        begin
            chk_err = cvs_pkg::ERR_CYCLES;
        end
    end

    // ------------------------------------------------------------------
    // Segment lookahead: find the next step after the point just taken,
    // skipping empty segments and counting down cycles on each wrap.
    // ------------------------------------------------------------------
    assign seg_start = (phase_reg == cvs_pkg::PH_EQUIL || seg_reg == 2'(cvs_pkg::SEG_UNUSED))
                       ? 2'(cvs_pkg::SEG_RISE) : seg_reg;
    assign step_ext  = signed'({{(WB-PB){1'b0}}, step_size_reg});

    assign seg_a[cvs_pkg::SEG_RISE]   = begin_reg;
    assign seg_b[cvs_pkg::SEG_RISE]   = vertex_one_reg;
    assign seg_a[cvs_pkg::SEG_CROSS]  = vertex_one_reg;
    assign seg_b[cvs_pkg::SEG_CROSS]  = vertex_two_reg;
    assign seg_a[cvs_pkg::SEG_RETURN] = vertex_two_reg;
    assign seg_b[cvs_pkg::SEG_RETURN] = begin_reg;

    // First step of each segment from its start, all segments side by side
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            first_cand[k] = step_level(seg_a[k], seg_b[k], WB'(seg_a[k]), step_ext);
            first_hit[k]  = (step_size_reg != '0) &&
                            step_fits(seg_a[k], seg_b[k], first_cand[k]);
        end
    end

    // Only the segment in progress continues from the drive level
    assign cont_cand = step_level(seg_a[seg_start], seg_b[seg_start], WB'(drive_reg), step_ext);
    assign cont_hit  = (step_size_reg != '0) &&
                       step_fits(seg_a[seg_start], seg_b[seg_start], cont_cand);

    always_comb
    begin
        adv_seg   = seg_start;
        adv_cyc   = cycles_left_reg;
        adv_found = 1'b0;
        adv_end   = 1'b0;
        adv_drive = drive_reg;
        adv_hit   = 1'b0;
        adv_cand  = '0;
        for (int i = 0; i < 4; i++)
        begin
            if (!adv_found && !adv_end)
            begin
                adv_hit  = (i == 0) ? cont_hit : first_hit[adv_seg];
                adv_cand = (i == 0) ? cont_cand : first_cand[adv_seg];
                if (adv_hit)
                begin
                    adv_found = 1'b1;
                    adv_drive = adv_cand[PB-1:0];
                end
                else if (adv_seg == 2'(cvs_pkg::SEG_RETURN))
                begin
                    adv_seg = 2'(cvs_pkg::SEG_RISE);
                    if (adv_cyc <= cvs_pkg::CYCLE_BITS'(1))
                    begin
                        adv_cyc = '0;
                        adv_end = 1'b1;
                    end
                    else
                    begin
                        adv_cyc = adv_cyc - 1'b1;
                    end
                end
                else
                begin
                    adv_seg = adv_seg + 1'b1;
                end
            end
        end
        // A whole cycle without a step leaves every remaining cycle empty
        if (!adv_found && !adv_end)
        begin
            adv_end = 1'b1;
            adv_cyc = '0;
        end
    end

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb
    begin
        phase_next       = phase_reg;
        drive_next       = drive_reg;
        seg_next         = seg_reg;
        cycles_left_next = cycles_left_reg;
        wait_next        = wait_reg;
        case (s1_mode_reg)
            cvs_pkg::MODE_START:
            begin
                if (chk_err != cvs_pkg::ERR_NONE)
                begin
                    phase_next = cvs_pkg::PH_IDLE;
                end
                else
                begin
                    phase_next       = cvs_pkg::PH_EQUIL;
                    drive_next       = begin_reg;
                    seg_next         = 2'(cvs_pkg::SEG_RISE);
                    cycles_left_next = cycles_cfg_reg;
                    wait_next        = equil_load;
                end
            end
            cvs_pkg::MODE_TICK:
            begin
                if (running)
                begin
                    wait_next = wait_dec;
                    if (sample_hit)
                    begin
                        cycles_left_next = adv_cyc;
                        if (adv_found)
                        begin
                            phase_next = cvs_pkg::PH_SWEEP;
                            drive_next = adv_drive;
                            seg_next   = adv_seg;
                            wait_next  = step_load;
                        end
                        else
                        begin
                            phase_next = cvs_pkg::PH_DONE;
                            seg_next   = seg_start;
                        end
                    end
                end
            end
            cvs_pkg::MODE_ABORT:
            begin
                if (running)
                begin
                    phase_next = cvs_pkg::PH_ABORT;
                end
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Result payload
    // ------------------------------------------------------------------
    always_comb
    begin
        res_point_valid = sample_hit;
        res_point_pot   = '0;
        res_point_cur   = '0;
        res_point_cell  = '0;
        res_err         = cvs_pkg::ERR_NONE;
        if (sample_hit)
        begin
            res_point_pot  = drive_reg;
            res_point_cur  = s1_current_reg;
            res_point_cell = s1_cell_reg;
        end
        if (s1_mode_reg == cvs_pkg::MODE_START)
        begin
            res_err = chk_err;
        end
    end

    // ------------------------------------------------------------------
    // State and result registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= cvs_pkg::PH_IDLE;
            drive_reg       <= '0;
            seg_reg         <= '0;
            cycles_left_reg <= '0;
            wait_reg        <= '0;
        end
        else if (do_step)
        begin
            phase_reg       <= phase_next;
            drive_reg       <= drive_next;
            seg_reg         <= seg_next;
            cycles_left_reg <= cycles_left_next;
            wait_reg        <= wait_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (pipe_move)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_step)
        begin
            out_point_valid_reg <= res_point_valid;
            out_point_pot_reg   <= res_point_pot;
            out_point_cur_reg   <= res_point_cur;
            out_point_cell_reg  <= res_point_cell;
            out_setpoint_reg    <= drive_next;
            out_phase_reg       <= phase_next;
            out_err_reg         <= res_err;
        end
    end

    assign out_valid          = out_valid_reg;
    assign point_valid        = out_point_valid_reg;
    assign point_potential    = out_point_pot_reg;
    assign point_current      = out_point_cur_reg;
    assign point_cell_voltage = out_point_cell_reg;
    assign setpoint           = out_setpoint_reg;
    assign phase              = out_phase_reg;
    assign error_code         = out_err_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
`include "cyclic_voltammetry_sequencer_top_assert.svh"

    `CVS_ASSERT_SAME(a_point_phase, out_valid_reg && out_point_valid_reg, (out_phase_reg == cvs_pkg::PH_SWEEP) || (out_phase_reg == cvs_pkg::PH_DONE), "point recorded outside a sweep")
    `CVS_ASSERT_SAME(a_err_idle, out_valid_reg && (out_err_reg != cvs_pkg::ERR_NONE), out_phase_reg == cvs_pkg::PH_IDLE, "start error did not stop the run")
    `CVS_ASSERT_NEXT(a_stall_hold, out_valid_reg && out_stall, $stable(phase_reg) && $stable(drive_reg) && $stable(wait_reg), "state moved while result stalled")
    `CVS_ASSERT_SAME(a_done_cycles, phase_reg == cvs_pkg::PH_DONE, cycles_left_reg == '0, "done with cycles left")
    `CVS_ASSERT_SAME(a_run_wait, running, wait_reg != '0, "running with empty wait counter")

endmodule

>>> tb/sv/cvs_sweep_monitor.sv
// ----------------------------------------------------------------------------
// Cyclic voltammetry sweep monitor
// Watches the configuration, sample and result channels of the sequencer,
// predicts the result beat of every accepted sample beat and compares the
// result beats field by field in order.
// ----------------------------------------------------------------------------
module cvs_sweep_monitor
    import cvs_pkg::*;
#(
    parameter int CURRENT_BITS = CURRENT_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          in_valid,
    input  logic                          in_stall,
    input  logic [1:0]                    mode,
    input  logic [CURRENT_BITS-1:0]       current_sample,
    input  logic [CELL_BITS-1:0]          cell_sample,

    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic                          point_valid,
    input  logic [POT_BITS-1:0]           point_potential,
    input  logic [CURRENT_BITS-1:0]       point_current,
    input  logic [CELL_BITS-1:0]          point_cell_voltage,
    input  logic [POT_BITS-1:0]           setpoint,
    input  logic [2:0]                    phase,
    input  logic [1:0]                    error_code,

    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [CFG_DATA_BITS-1:0]      cfg_data,

    output int                            failures,
    output int                            pending,
    output int                            points
);

    localparam int REPORT_CAP = 200;

    typedef struct packed {
        logic                    pv;
        logic [POT_BITS-1:0]     pot;
        logic [CURRENT_BITS-1:0] cur;
        logic [CELL_BITS-1:0]    volt;
        logic [POT_BITS-1:0]     setp;
        phase_t                  ph;
        err_t                    err;
    } reading_t;

    reading_t queued_readings[$];
    int       reports;

    // Register copy
    logic signed [POT_BITS-1:0]     r_begin;
    logic signed [POT_BITS-1:0]     r_vertex_one;
    logic signed [POT_BITS-1:0]     r_vertex_two;
    logic [POT_BITS-1:0]            r_step;
    logic [STEP_TIME_BITS-1:0]      r_step_time;
    logic [WAIT_BITS-1:0]           r_equil;
    logic [CYCLE_BITS-1:0]          r_cycles;

    // Sequencer state
    phase_t run_ph;
    int     drive;
    int     seg_idx;
    int     cyc_left;
    int     wait_cnt;

    function automatic int seg_start(int s);
        return (s == SEG_RISE) ? int'(r_begin) :
               (s == SEG_CROSS) ? int'(r_vertex_one) : int'(r_vertex_two);
    endfunction

    function automatic int seg_end(int s);
        return (s == SEG_RISE) ? int'(r_vertex_one) :
               (s == SEG_CROSS) ? int'(r_vertex_two) : int'(r_begin);
    endfunction

    function automatic int wait_reload(int ticks);
        return (ticks == 0) ? 1 : ticks;
    endfunction

    // Move to the next step after the recorded point; skip segments too short
    // for one step and end the scan when the cycles run out.
    function automatic void seek_next_step();
        int s;
        int stp;
        int a;
        int b;
        int dir;
        int from;
        int cand;
        s = (seg_idx > SEG_RETURN) ? SEG_RISE : seg_idx;
        stp = int'(r_step);
        for (int i = 0; i < 4; i++)
        begin
            if (stp > 0)
            begin
                a = seg_start(s);
                b = seg_end(s);
                dir = (b >= a) ? 1 : -1;
                from = (i == 0) ? drive : a;
                cand = from + dir * stp;
                if ((b - cand) * dir >= 0)
                begin
                    drive = cand;
                    seg_idx = s;
                    wait_cnt = wait_reload(int'(r_step_time));
                    return;
                end
            end
            s++;
            if (s == 3)
            begin
                s = SEG_RISE;
                if (cyc_left <= 1)
                begin
                    cyc_left = 0;
                    run_ph = PH_DONE;
                    return;
                end
                cyc_left--;
            end
        end
        cyc_left = 0;
        run_ph = PH_DONE;
    endfunction

    function automatic reading_t step_sequencer(logic [1:0] m, logic [CURRENT_BITS-1:0] cur,
                                                logic [CELL_BITS-1:0] volt);
        reading_t r;
        r = '0;
        r.err = ERR_NONE;
        case (mode_t'(m))
            MODE_START:
            begin
                if (r_begin > POT_LIMIT || r_begin < POT_LIMIT_NEG ||
                    r_vertex_one > POT_LIMIT || r_vertex_one < POT_LIMIT_NEG ||
                    r_vertex_two > POT_LIMIT || r_vertex_two < POT_LIMIT_NEG)
                    r.err = ERR_RANGE;
                else if (r_step == '0)
                    r.err = ERR_STEP;
                else if (r_cycles == '0)
                    r.err = ERR_CYCLES;
                if (r.err != ERR_NONE)
                    run_ph = PH_IDLE;
                else
                begin
                    run_ph = PH_EQUIL;
                    drive = int'(r_begin);
                    seg_idx = SEG_RISE;
                    cyc_left = int'(r_cycles);
                    wait_cnt = wait_reload(int'(r_equil));
                end
            end
            MODE_TICK:
            begin
                if (run_ph == PH_EQUIL || run_ph == PH_SWEEP)
                begin
                    if (wait_cnt > 0)
                        wait_cnt--;
                    if (wait_cnt == 0)
                    begin
                        r.pv = 1'b1;
                        r.pot = drive[POT_BITS-1:0];
                        r.cur = cur;
                        r.volt = volt;
                        if (run_ph == PH_EQUIL)
                        begin
                            run_ph = PH_SWEEP;
                            seg_idx = SEG_RISE;
                        end
                        seek_next_step();
                    end
                end
            end
            MODE_ABORT:
            begin
                if (run_ph == PH_EQUIL || run_ph == PH_SWEEP)
                    run_ph = PH_ABORT;
            end
            default: ;
        endcase
        r.setp = drive[POT_BITS-1:0];
        r.ph = run_ph;
        return r;
    endfunction

    function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            failures++;
            if (reports < REPORT_CAP)
            begin
                $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
                reports++;
            end
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        reading_t want;
        if (!rst_n)
        begin
            r_begin = BEGIN_RST;
            r_vertex_one = VERTEX_ONE_RST;
            r_vertex_two = VERTEX_TWO_RST;
            r_step = STEP_SIZE_RST;
            r_step_time = STEP_TIME_RST;
            r_equil = EQUIL_RST;
            r_cycles = CYCLE_RST;
            run_ph = PH_IDLE;
            drive = 0;
            seg_idx = 0;
            cyc_left = 0;
            wait_cnt = 0;
            queued_readings.delete();
            failures = 0;
            reports = 0;
            points = 0;
            pending = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (reg_index_t'(cfg_index))
                    REG_BEGIN:      r_begin = cfg_data[POT_BITS-1:0];
                    REG_VERTEX_ONE: r_vertex_one = cfg_data[POT_BITS-1:0];
                    REG_VERTEX_TWO: r_vertex_two = cfg_data[POT_BITS-1:0];
                    REG_STEP_SIZE:  r_step = cfg_data[POT_BITS-1:0];
                    REG_STEP_TIME:  r_step_time = cfg_data[STEP_TIME_BITS-1:0];
                    REG_EQUIL:      r_equil = cfg_data[WAIT_BITS-1:0];
                    REG_CYCLES:     r_cycles = cfg_data[CYCLE_BITS-1:0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                want = step_sequencer(mode, current_sample, cell_sample);
                if (want.pv)
                    points++;
                queued_readings.push_back(want);
            end
            if (out_valid && !out_stall)
            begin
                if (queued_readings.size() == 0)
                begin
                    failures++;
                    if (reports < REPORT_CAP)
                    begin
                        $display("%0t: result beat with no sample beat behind it", $time);
                        reports++;
                    end
                end
                else
                begin
                    want = queued_readings.pop_front();
                    compare_field("point_valid", want.pv, point_valid);
                    compare_field("point_potential", want.pot, point_potential);
                    compare_field("point_current", want.cur, point_current);
                    compare_field("point_cell_voltage", want.volt, point_cell_voltage);
                    compare_field("setpoint", want.setp, setpoint);
                    compare_field("phase", want.ph, phase);
                    compare_field("error_code", want.err, error_code);
                end
            end
            pending = queued_readings.size();
        end
    end

endmodule

>>> tb/sv/cyclic_voltammetry_sequencer_top_tb.sv
// ----------------------------------------------------------------------------
// Cyclic voltammetry sequencer testbench
// Drives configuration writes and start, tick, abort and no-op beats through
// directed cases and random sweeps under varying sender gaps and receiver
// stalls; the sweep monitor predicts and checks every result beat.
// ----------------------------------------------------------------------------
module cyclic_voltammetry_sequencer_top_tb;
    import cvs_pkg::*;

    localparam int CUR_BITS    = CURRENT_BITS_DEF;
    localparam int BEAT_TARGET = 1950;
    localparam int QUIET_LIMIT = 4000;
    localparam int HOLD_CYCLES = 80;

    logic                        clk = 1'b0;
    logic                        rst_n;

    logic                        in_valid;
    logic                        in_stall;
    logic [1:0]                  mode;
    logic [CUR_BITS-1:0]         current_sample;
    logic [CELL_BITS-1:0]        cell_sample;

    logic                        out_valid;
    logic                        out_stall;
    logic                        point_valid;
    logic [POT_BITS-1:0]         point_potential;
    logic [CUR_BITS-1:0]         point_current;
    logic [CELL_BITS-1:0]        point_cell_voltage;
    logic [POT_BITS-1:0]         setpoint;
    logic [2:0]                  phase;
    logic [1:0]                  error_code;

    logic                        cfg_valid;
    logic                        cfg_ready;
    logic [CFG_INDEX_BITS-1:0]   cfg_index;
    logic [CFG_DATA_BITS-1:0]    cfg_data;

    int failures;
    int pending;
    int points;

    int gap_pct;
    int stall_pct;
    int hold_reqs;
    int holds_served;
    int hold_left;
    int quiet;
    int beats_sent;
    int scans;
    int rejected;

    always #5 clk = ~clk;

    cyclic_voltammetry_sequencer_top #(
        .CURRENT_BITS(CUR_BITS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .mode(mode),
        .current_sample(current_sample),
        .cell_sample(cell_sample),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .point_valid(point_valid),
        .point_potential(point_potential),
        .point_current(point_current),
        .point_cell_voltage(point_cell_voltage),
        .setpoint(setpoint),
        .phase(phase),
        .error_code(error_code),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    cvs_sweep_monitor #(
        .CURRENT_BITS(CUR_BITS)
    ) monitor (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .mode(mode),
        .current_sample(current_sample),
        .cell_sample(cell_sample),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .point_valid(point_valid),
        .point_potential(point_potential),
        .point_current(point_current),
        .point_cell_voltage(point_cell_voltage),
        .setpoint(setpoint),
        .phase(phase),
        .error_code(error_code),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .failures(failures),
        .pending(pending),
        .points(points)
    );

    // Receiver: random stalls, plus a long hold whenever one is requested
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else if (holds_served != hold_reqs)
        begin
            holds_served <= holds_served + 1;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT)
        begin
            $display("%0t: no beat moved for %0d cycles", $time, QUIET_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Hold cfg_valid high; the caller drops it after the last write
    task automatic cfg_write(reg_index_t idx, int val);
        logic [CFG_DATA_BITS-1:0] keep;
        logic [CFG_DATA_BITS-1:0] junk;
        case (idx)
            REG_STEP_TIME: keep = 20'h0FFFF;
            REG_EQUIL:     keep = 20'hFFFFF;
            REG_CYCLES:    keep = 20'h000FF;
            default:       keep = 20'h07FFF;
        endcase
        junk = CFG_DATA_BITS'($urandom);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= (junk & ~keep) | (CFG_DATA_BITS'(val) & keep);
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic cfg_done();
        cfg_valid <= 1'b0;
    endtask

    task automatic program_scan(int b, int v1, int v2, int stp, int st, int eq, int cyc);
        cfg_write(REG_BEGIN, b);
        cfg_write(REG_VERTEX_ONE, v1);
        cfg_write(REG_VERTEX_TWO, v2);
        cfg_write(REG_STEP_SIZE, stp);
        cfg_write(REG_STEP_TIME, st);
        cfg_write(REG_EQUIL, eq);
        cfg_write(REG_CYCLES, cyc);
        cfg_done();
    endtask

    task automatic beat_with(mode_t m, logic [CUR_BITS-1:0] cur, logic [CELL_BITS-1:0] volt);
        if ($urandom_range(99) < gap_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid <= 1'b1;
        mode <= m;
        current_sample <= cur;
        cell_sample <= volt;
        do @(posedge clk); while (in_stall);
        beats_sent++;
    endtask

    task automatic beat(mode_t m);
        beat_with(m, CUR_BITS'($urandom), CELL_BITS'($urandom));
    endtask

    // Drop valid and wait until every result beat is back
    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    function automatic int span_of(int a, int b);
        return (a > b) ? a - b : b - a;
    endfunction

    function automatic int bad_potential();
        return $urandom_range(1) ? int'($urandom_range(10001, 16383))
                                 : -int'($urandom_range(10001, 16384));
    endfunction

    task automatic run_directed();
        // Unused register index must be ignored
        cfg_write(REG_NONE, 'h5A5A5);
        cfg_done();
        beat(MODE_NOP);
        beat(MODE_TICK);
        beat(MODE_ABORT);
        beat(MODE_START);
        beat_with(MODE_TICK, 24'h800000, 16'h8000);
        beat_with(MODE_TICK, 24'h7FFFFF, 16'h7FFF);
        beat(MODE_START);
        beat(MODE_TICK);
        beat(MODE_ABORT);
        beat(MODE_TICK);
        drain();

        // Full-scale sweep, one step per segment, return segment empty
        program_scan(-10000, 10000, -10000, 20000, 0, 0, 2);
        beat(MODE_START);
        repeat (6) beat(MODE_TICK);
        drain();

        // Start check order: range, then step, then cycles
        program_scan(16383, 0, 0, 0, 1, 1, 0);
        beat(MODE_START);
        drain();
        cfg_write(REG_BEGIN, 0);
        cfg_done();
        beat(MODE_START);
        drain();
        cfg_write(REG_STEP_SIZE, 32767);
        cfg_done();
        beat(MODE_START);
        drain();
        rejected += 3;

        // Longest waits
        program_scan(0, 5, -5, 1, 65535, 1048575, 255);
        beat(MODE_START);
        beat(MODE_TICK);
        beat(MODE_ABORT);
        drain();

        // No step fits in a cycle: done right after the begin point
        program_scan(0, 5, -5, 32767, 65535, 0, 255);
        beat(MODE_START);
        beat(MODE_TICK);
        drain();
    endtask

    task automatic run_scan();
        int b;
        int v1;
        int v2;
        int stp;
        int st;
        int eq;
        int cyc;
        int span;
        int steps;
        int ticks;
        int kind;
        int r;

        if (beats_sent < 650)
        begin
            gap_pct <= 12;
            stall_pct <= 56;
        end
        else if (beats_sent < 1300)
        begin
            gap_pct <= 56;
            stall_pct <= 12;
        end
        else
        begin
            gap_pct <= 0;
            stall_pct <= 0;
        end

        b = int'($urandom_range(20000)) - 10000;
        v1 = int'($urandom_range(20000)) - 10000;
        v2 = int'($urandom_range(20000)) - 10000;
        st = $urandom_range(3);
        eq = $urandom_range(4);
        cyc = $urandom_range(1, 3);
        kind = $urandom_range(99);
        if (kind < 5)
        begin
            // flat sweep: every cycle empty
            v1 = b;
            v2 = b;
            cyc = $urandom_range(1) ? 255 : $urandom_range(1, 254);
        end
        span = span_of(b, v1) + span_of(v1, v2) + span_of(v2, b);
        if ($urandom_range(9) == 0)
            stp = $urandom_range(20001, 32767);
        else
            stp = span / $urandom_range(3, 16);
        if (stp == 0)
            stp = 1;
        steps = span_of(b, v1) / stp + span_of(v1, v2) / stp + span_of(v2, b) / stp;
        ticks = (eq > 0 ? eq : 1) + cyc * steps * (st > 0 ? st : 1) + $urandom_range(3);

        if (kind >= 5 && kind < 13)
        begin
            // malformed configuration, start gets rejected
            case ($urandom_range(3))
                0: b = bad_potential();
                1: v2 = bad_potential();
                2: stp = 0;
                default: cyc = 0;
            endcase
            ticks = $urandom_range(1, 3);
            rejected++;
        end

        program_scan(b, v1, v2, stp, st, eq, cyc);
        beat(MODE_START);
        if (scans % 20 == 1)
            hold_reqs <= hold_reqs + 1;
        for (int i = 0; i < ticks; i++)
        begin
            r = $urandom_range(99);
            if (r < 3)
                beat(MODE_ABORT);
            else if (r < 6)
                beat(MODE_NOP);
            else if (r < 8)
                beat(MODE_START);
            else
                beat(MODE_TICK);
        end
        // leave the sequencer stopped before the next configuration
        beat(MODE_ABORT);
        drain();
        scans++;
    endtask

    initial
    begin
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        mode <= MODE_NOP;
        current_sample <= '0;
        cell_sample <= '0;
        out_stall <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_NONE;
        cfg_data <= '0;
        gap_pct <= 12;
        stall_pct <= 56;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        while (beats_sent < BEAT_TARGET)
            run_scan();

        repeat (8) @(posedge clk);
        $display("Covered %0d beats: directed cases and %0d random sweeps", beats_sent, scans);
        $display("with %0d rejected starts and %0d recorded points", rejected, points);
        if (failures == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
